// ----- src/fifo_with_delete_by_value_macros.svh -----
// assertion helpers for the verification checker
// both expect i_clk and i_rst_n in the scope where they are used
`ifndef FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH
`define FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FWDV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fwdv assertion failed");

// next-cycle implication, disabled while in reset
`define FWDV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fwdv assertion failed");

`endif

// ----- src/fwdv_pkg.sv -----
package fwdv_pkg;

    // fixed field widths
    localparam int COUNT_W  = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // request operation codes
    localparam t_op OP_ENQUEUE = 2'd0;
    localparam t_op OP_DEQUEUE = 2'd1;
    localparam t_op OP_DELETE  = 2'd2;

    // response status codes
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NULL      = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;

    // per-cycle command broadcast along the cell row
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ENQ,
        CM_SHIFT,
        CM_ROTATE
    } t_cell_mode;

endpackage

// ----- src/fwdv_if.sv -----
// request channel: operation and data word
interface fwdv_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    fwdv_pkg::t_op         operation;
    logic [DATA_WIDTH-1:0] item;

    modport source (output valid, output operation, output item, input ready);
    modport sink   (input valid, input operation, input item, output ready);
endinterface

// response channel: status, removed word and occupancy
interface fwdv_rsp_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    fwdv_pkg::t_status     status;
    logic [DATA_WIDTH-1:0] item_out;
    fwdv_pkg::t_count      count;

    modport source (output valid, output status, output item_out, output count, input ready);
    modport sink   (input valid, input status, input item_out, input count, output ready);
endinterface

// ----- src/fwdv_cell.sv -----
module fwdv_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fwdv_pkg::t_cell_mode   i_mode,
    input  logic [DATA_WIDTH-1:0]  i_bcast,
    input  logic                   i_prev_valid,
    input  logic                   i_next_valid,
    input  logic [DATA_WIDTH-1:0]  i_next_word,
    output logic                   o_valid,
    output logic [DATA_WIDTH-1:0]  o_word
);
    import fwdv_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    // next contents from the row command and the neighbours
    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        case (i_mode)
            CM_HOLD: begin
                n_valid = r_valid;
            end
            CM_ENQ: begin
                // first empty cell takes the new word
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_word  = i_bcast;
                end
            end
            CM_SHIFT: begin
                n_valid = i_next_valid;
                n_word  = i_next_word;
            end
            CM_ROTATE: begin
                // tail cell takes the old head back, the rest move up
                if (r_valid && !i_next_valid) begin
                    n_word = i_bcast;
                end else begin
                    n_valid = i_next_valid;
                    n_word  = i_next_word;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stored word
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- src/fwdv_ctrl.sv -----
module fwdv_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    fwdv_req_if.sink               i_req,
    fwdv_rsp_if.source             o_rsp,
    input  logic [DATA_WIDTH-1:0]  i_head_word,
    output fwdv_pkg::t_cell_mode   o_mode,
    output logic [DATA_WIDTH-1:0]  o_bcast
);
    import fwdv_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;
    logic                  r_found;
    logic                  n_found;
    logic [DATA_WIDTH-1:0] r_match_word;
    logic [DATA_WIDTH-1:0] n_match_word;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [DATA_WIDTH-1:0] r_item_out;
    logic [DATA_WIDTH-1:0] n_item_out;
    t_count                r_cnt_out;
    t_count                n_cnt_out;

    logic                  w_ready;
    logic                  w_accept;
    logic                  w_res_load;
    t_status               w_res_status;
    logic [DATA_WIDTH-1:0] w_res_item;
    logic                  w_head_hit;

    // take a request only when idle and the output slot frees up
    assign w_ready    = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept   = i_req.valid && w_ready;
    assign w_head_hit = !r_found && (i_head_word == r_match_word);

    // operation decode, delete scan sequencing and response build
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_found      = r_found;
        n_match_word = r_match_word;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_status     = r_status;
        n_item_out   = r_item_out;
        n_cnt_out    = r_cnt_out;
        w_res_load   = 1'b0;
        w_res_status = ST_OK;
        w_res_item   = '0;
        o_mode       = CM_HOLD;
        o_bcast      = i_req.item;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_res_load = 1'b1;
                    case (i_req.operation)
                        OP_ENQUEUE: begin
                            if (i_req.item == '0) begin
                                w_res_status = ST_NULL;
                            end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                w_res_status = ST_FULL;
                            end else begin
                                o_mode  = CM_ENQ;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_DEQUEUE: begin
                            if (r_count == '0) begin
                                w_res_status = ST_EMPTY;
                            end else begin
                                o_mode     = CM_SHIFT;
                                w_res_item = i_head_word;
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (i_req.item == '0) begin
                                w_res_status = ST_NULL;
                            end else if (r_count == '0) begin
                                w_res_status = ST_NOT_FOUND;
                            end else begin
                                // rotate the whole row once through the head
                                w_res_load   = 1'b0;
                                n_state      = S_SCAN;
                                n_left       = r_count;
                                n_found      = 1'b0;
                                n_match_word = i_req.item;
                            end
                        end
                        default: begin
                            w_res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // first matching head word is dropped, others go to the tail
                o_bcast = i_head_word;
                if (w_head_hit) begin
                    o_mode  = CM_SHIFT;
                    n_found = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end else begin
                    o_mode = CM_ROTATE;
                end
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_res_load   = 1'b1;
                    w_res_status = r_found ? ST_OK : ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // response register load
        if (w_res_load) begin
            n_out_valid = 1'b1;
            n_status    = w_res_status;
            n_item_out  = w_res_item;
            n_cnt_out   = COUNT_W'(n_count);
        end
    end

    // state, counters and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_match_word <= n_match_word;
        r_status     <= n_status;
        r_item_out   <= n_item_out;
        r_cnt_out    <= n_cnt_out;
    end

    assign i_req.ready    = w_ready;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.item_out = r_item_out;
    assign o_rsp.count    = r_cnt_out;

endmodule

// ----- src/fifo_with_delete_by_value.sv -----
// FIFO of nonzero words with delete of the first matching word.
// i_req (sink): operation (enqueue, dequeue, delete) and item; a beat is taken
// when valid and ready are both high at a rising edge of i_clk.
// o_rsp (source): status, item_out (word removed by dequeue, else zero) and
// count (stored words after the operation), one response beat per request.
// Storage is a row of QUEUE_DEPTH cells, cell 0 holding the head.
// Enqueue, dequeue and every rejected request: response valid the cycle after
// the request beat; the next request can be taken in the following cycle.
// Delete of a nonzero word with N words stored: the row rotates through the
// head compare once, one cell step a cycle, and the response is then loaded
// in S_DONE; ready stays low from the request beat until that load.
// A stalled response is held in the output register; one more request is
// taken meanwhile only if its response can enter as the held beat leaves.
// i_rst_n (synchronous, active low) empties the queue and drops any
// pending response; stored words are not cleared and are never read.
module fifo_with_delete_by_value #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fwdv_req_if.sink   i_req,
    fwdv_rsp_if.source o_rsp
);
    import fwdv_pkg::*;

    t_cell_mode            w_mode;
    logic [DATA_WIDTH-1:0] w_bcast;
    logic                  w_valid [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] w_word  [QUEUE_DEPTH];

    // sequencer and response register
    fwdv_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_head_word (w_word[0]),
        .o_mode      (w_mode),
        .o_bcast     (w_bcast)
    );

    // row of storage cells, each linked to both neighbours
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                  w_prev_valid;
        logic                  w_next_valid;
        logic [DATA_WIDTH-1:0] w_next_word;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_word  = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_word  = w_word[g+1];
        end

        fwdv_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_mode       (w_mode),
            .i_bcast      (w_bcast),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_word  (w_next_word),
            .o_valid      (w_valid[g]),
            .o_word       (w_word[g])
        );
    end

endmodule

// ----- src/fwdv_checker.sv -----
`include "fifo_with_delete_by_value_macros.svh"

module fwdv_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input fwdv_pkg::t_status     i_rsp_status,
    input logic [DATA_WIDTH-1:0] i_rsp_item_out,
    input fwdv_pkg::t_count      i_rsp_count
);
    import fwdv_pkg::*;

    logic [STATUS_W+DATA_WIDTH+COUNT_W-1:0] w_payload;
    logic                                   w_full_cnt;

    assign w_payload  = {i_rsp_status, i_rsp_item_out, i_rsp_count};
    assign w_full_cnt = (i_rsp_count == COUNT_W'(QUEUE_DEPTH));

    // a stalled response beat holds
    `FWDV_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(w_payload))

    // only a response with status OK may return a word
    `FWDV_ASSERT_IMP(a_item_ok, i_rsp_valid && (i_rsp_status != ST_OK), i_rsp_item_out == '0)

    // empty is reported only with nothing stored
    `FWDV_ASSERT_IMP(a_empty_cnt, i_rsp_valid && (i_rsp_status == ST_EMPTY), i_rsp_count == '0)

    // full is reported only at capacity
    `FWDV_ASSERT_IMP(a_full_cnt, i_rsp_valid && (i_rsp_status == ST_FULL), w_full_cnt)

endmodule

bind fifo_with_delete_by_value fwdv_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
) u_fwdv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_item_out (o_rsp.item_out),
    .i_rsp_count    (o_rsp.count)
);
